// ===== rtl/lps_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lps_pkg
// Shared sizes, action codes and types of the least-recently-used key set.
// ---------------------------------------------------------------------------
package lps_pkg;

   // number of key slots
   localparam int ENTRIES = 16;

   // fixed field widths
   localparam int KEY_W    = 64;
   localparam int ACTION_W = 2;
   localparam int CAP_W    = 5;
   localparam int OCC_W    = 5;

   // derived widths
   localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

   typedef logic [ENTRIES-1:0][KEY_W-1:0] key_array_type;
   typedef logic [ENTRIES-1:0][AGE_W-1:0] age_array_type;

   // outcome of the parallel tag compare
   typedef struct packed {
      logic               present;
      logic [ENTRIES-1:0] hit;
      logic [AGE_W-1:0]   hit_age;
   } lps_match_type;

endpackage : lps_pkg
`default_nettype wire

// ===== rtl/lps_tag_match.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lps_tag_match
// Compares one key against every valid slot and returns the hit slot and
// its recency rank.
// ---------------------------------------------------------------------------
module lps_tag_match
   import lps_pkg::*;
(
   input  wire logic [ENTRIES-1:0] entry_valid,
   input  wire key_array_type      entry_key,
   input  wire age_array_type      entry_age,
   input  wire logic [KEY_W-1:0]   key,
   output lps_match_type           match
);

   logic [ENTRIES-1:0] hit;
   logic [AGE_W-1:0]   hit_age;

   // one comparator per slot, at most one slot can hit
   always_comb begin
      hit_age = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit[i] = entry_valid[i] && (entry_key[i] == key);
         if (hit[i]) begin
            hit_age = hit_age | entry_age[i];
         end
      end
   end

   assign match.present = |hit;
   assign match.hit     = hit;
   assign match.hit_age = hit_age;

endmodule : lps_tag_match
`default_nettype wire

// ===== rtl/lru_presence_set_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lru_presence_set_unit
// Fully associative set of 64-bit keys kept in least-recently-used order.
// ---------------------------------------------------------------------------
// Usage:
//   req_ channel carries one request (action, key); rsp_ channel returns one
//   result per request (present, occupancy). Both use valid/stall, a request
//   moves when valid is high and stall is low.
//   csr_ channel writes the capacity register (always ready); write it only
//   while no request is in flight.
//   A request is held in an input register; the parallel tag compare and
//   rank update then run on it and the result register is loaded once the
//   result channel can advance. One request per cycle is sustained while the
//   receiver does not stall; the figure is set by the parallel compare of all
//   slots and the rank update that feeds the slot state.
//   Reset empties the set and sets capacity to its full value.
//   When the receiver stalls, the result register holds, the input register
//   holds its request and req_stall is raised until the result is taken.
// ---------------------------------------------------------------------------
module lru_presence_set_unit
   import lps_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [ACTION_W-1:0] req_action,
   input  wire logic [KEY_W-1:0]    req_key,
   // result channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_present,
   output logic [OCC_W-1:0]         rsp_occupancy,
   // capacity register write
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CAP_W-1:0]    csr_data
);

   // input register
   logic                s1_valid_ff, s1_valid_in;
   logic [ACTION_W-1:0] s1_action_ff;
   logic [KEY_W-1:0]    s1_key_ff;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_present_ff, rsp_present_in;
   logic [OCC_W-1:0] rsp_occ_ff, rsp_occ_in;

   // set state
   logic [CAP_W-1:0]   capacity_ff;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   key_array_type      key_ff, key_in;
   age_array_type      age_ff, age_in;
   logic [CNT_W-1:0]   held_ff, held_in;

   logic               advance;
   lps_match_type      match;
   logic [CMP_W-1:0]   cap_eff;
   logic [CMP_W-1:0]   held_wide;
   logic [CMP_W-1:0]   held_kept;
   logic [CMP_W-1:0]   held_next;
   logic [ENTRIES-1:0] valid_kept;
   logic [ENTRIES-1:0] free_vec;
   logic [ENTRIES-1:0] free_onehot;

   // handshake
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = s1_valid_ff && !advance;
   assign csr_ready   = 1'b1;
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   // tag compare
   lps_tag_match u_match (
      .entry_valid (valid_ff),
      .entry_key   (key_ff),
      .entry_age   (age_ff),
      .key         (s1_key_ff),
      .match       (match)
   );

   // effective capacity and eviction of the oldest ranks
   always_comb begin
      if (CMP_W'(capacity_ff) > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end else begin
         cap_eff = CMP_W'(capacity_ff);
      end
      held_wide = CMP_W'(held_ff);
      for (int i = 0; i < ENTRIES; i++) begin
         valid_kept[i] = valid_ff[i] && (CMP_W'(age_ff[i]) < (cap_eff - CMP_W'(1)));
      end
      if (held_wide >= cap_eff) begin
         held_kept = cap_eff - CMP_W'(1);
      end else begin
         held_kept = held_wide;
      end
      free_vec    = ~valid_kept;
      free_onehot = free_vec & (~free_vec + ENTRIES'(1));
   end

   // state update and result
   always_comb begin
      valid_in       = valid_ff;
      key_in         = key_ff;
      age_in         = age_ff;
      held_in        = held_ff;
      held_next      = held_wide;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_present_in = rsp_present_ff;
      rsp_occ_in     = rsp_occ_ff;
      if (s1_valid_ff && advance) begin
         rsp_valid_in   = 1'b1;
         rsp_present_in = match.present;
         case (s1_action_ff)
            ACT_CLEAR: begin
               valid_in       = '0;
               age_in         = '0;
               held_next      = '0;
               rsp_present_in = 1'b0;
            end
            ACT_INSERT: begin
               if (capacity_ff != '0) begin
                  if (match.present) begin
                     // refresh: younger ranks move down by one
                     for (int i = 0; i < ENTRIES; i++) begin
                        if (match.hit[i]) begin
                           age_in[i] = '0;
                        end else if (valid_ff[i] && (age_ff[i] < match.hit_age)) begin
                           age_in[i] = age_ff[i] + AGE_W'(1);
                        end
                     end
                  end else begin
                     // new key into the lowest free slot
                     for (int i = 0; i < ENTRIES; i++) begin
                        if (free_onehot[i]) begin
                           valid_in[i] = 1'b1;
                           key_in[i]   = s1_key_ff;
                           age_in[i]   = '0;
                        end else begin
                           valid_in[i] = valid_kept[i];
                           if (valid_kept[i]) begin
                              age_in[i] = age_ff[i] + AGE_W'(1);
                           end
                        end
                     end
                     held_next = held_kept + CMP_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
         held_in    = held_next[CNT_W-1:0];
         rsp_occ_in = held_next[OCC_W-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= CAP_W'(16);
         valid_ff     <= '0;
         age_ff       <= '0;
         held_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         age_ff       <= age_in;
         held_ff      <= held_in;
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_action_ff <= req_action;
         s1_key_ff    <= req_key;
      end
      key_ff         <= key_in;
      rsp_present_ff <= rsp_present_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_present   = rsp_present_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule : lru_presence_set_unit
`default_nettype wire

// ===== tb/lru_presence_set_unit_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lru_presence_set_unit_test
// Drives lookup, insert and clear requests into the least-recently-used key
// set under several capacity values, random idles and receiver stalls, and
// checks every presence flag and occupancy against a behavioural copy of the
// set that tracks keys, recency ranks and evictions.
// ---------------------------------------------------------------------------
import lps_pkg::*;

// behavioural copy of the key set plus the queue of outcomes still owed
class key_set_tracker;

   typedef struct packed {
      logic             present;
      logic [OCC_W-1:0] occupancy;
   } set_outcome_type;

   bit               slot_used [ENTRIES];
   logic [KEY_W-1:0] slot_key  [ENTRIES];
   int unsigned      slot_rank [ENTRIES];
   int unsigned      held;
   logic [CAP_W-1:0] capacity;
   set_outcome_type  owed_outcomes [$];
   int               mismatches;

   function new();
      foreach (slot_used[i]) begin
         slot_used[i] = 1'b0;
         slot_key[i]  = '0;
         slot_rank[i] = 0;
      end
      held       = 0;
      capacity   = CAP_W'(16);
      mismatches = 0;
   endfunction

   // apply one accepted request to the copy and queue its outcome
   function void note_request(logic [ACTION_W-1:0] action, logic [KEY_W-1:0] key);
      int              hit;
      int              free_slot;
      int unsigned     limit;
      int unsigned     old_rank;
      set_outcome_type outcome;
      hit = -1;
      outcome.present = 1'b0;
      if (action == ACT_CLEAR) begin
         foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
            slot_rank[i] = 0;
         end
         held = 0;
      end else begin
         foreach (slot_used[i])
            if (slot_used[i] && slot_key[i] == key && hit < 0) hit = i;
         outcome.present = (hit >= 0);
         if (action == ACT_INSERT && capacity != 0) begin
            if (hit >= 0) begin
               // refresh: younger keys age by one, hit key becomes newest
               old_rank = slot_rank[hit];
               foreach (slot_used[i])
                  if (slot_used[i] && slot_rank[i] < old_rank) slot_rank[i]++;
               slot_rank[hit] = 0;
            end else begin
               limit = (capacity > ENTRIES) ? ENTRIES : capacity;
               // drop the oldest keys until there is room under the limit
               while (held >= limit && held > 0) begin
                  foreach (slot_used[i])
                     if (slot_used[i] && slot_rank[i] == held - 1) begin
                        slot_used[i] = 1'b0;
                        slot_rank[i] = 0;
                     end
                  held--;
               end
               free_slot = -1;
               foreach (slot_used[i]) begin
                  if (slot_used[i]) slot_rank[i]++;
                  else if (free_slot < 0) free_slot = i;
               end
               slot_used[free_slot] = 1'b1;
               slot_key[free_slot]  = key;
               slot_rank[free_slot] = 0;
               held++;
            end
         end
      end
      outcome.occupancy = OCC_W'(held);
      owed_outcomes.push_back(outcome);
   endfunction

   // compare one accepted result with the oldest owed outcome
   function void check_result(logic present, logic [OCC_W-1:0] occupancy);
      set_outcome_type want;
      if (owed_outcomes.size() == 0) begin
         $error("unexpected result: present %0d occupancy %0d", present, occupancy);
         mismatches++;
      end else begin
         want = owed_outcomes.pop_front();
         if (present !== want.present) begin
            $error("present: expected %0d, actual %0d", want.present, present);
            mismatches++;
         end
         if (occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, occupancy);
            mismatches++;
         end
      end
   endfunction

endclass

module lru_presence_set_unit_test;

   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;  // undefined code, acts as lookup
   localparam int QUIET_LIMIT   = 2000;
   localparam int LONG_HOLD     = 60;
   localparam int SEGMENT_ITEMS = 100;
   localparam int POOL_SIZE     = 24;
   localparam int TAIL_CYCLES   = 5;

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action  = ACT_LOOKUP;
   logic [KEY_W-1:0]    req_key     = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic                rsp_present;
   logic [OCC_W-1:0]    rsp_occupancy;
   logic                csr_valid   = 1'b0;
   logic                csr_ready;
   logic [CAP_W-1:0]    csr_data    = '0;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_asked         = 0;
   int hold_granted       = 0;
   int hold_left          = 0;
   int quiet_cycles       = 0;

   key_set_tracker tracker = new();

   lru_presence_set_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_present   (rsp_present),
      .rsp_occupancy (rsp_occupancy),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, or a long hold-off when one is asked for
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_asked != hold_granted) begin
         hold_granted = hold_asked;
         hold_left    = LONG_HOLD - 1;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // result monitor
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result(rsp_present, rsp_occupancy);

   // watchdog: count cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // offer one request, with random idle cycles ahead of it
   task automatic send_request(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] k);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_key    <= k;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(act, k);
   endtask

   // stop offering and wait until every owed result has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.owed_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.capacity = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random requests over a small key pool so that hits and evictions are common
   task automatic run_segment(input int count);
      logic [KEY_W-1:0]    pool [POOL_SIZE];
      logic [KEY_W-1:0]    k;
      logic [ACTION_W-1:0] act;
      int                  pick;
      foreach (pool[i]) pool[i] = {$urandom, $urandom};
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 50)      act = ACT_INSERT;
         else if (pick < 92) act = ACT_LOOKUP;
         else if (pick < 98) act = ACT_SPARE;
         else                act = ACT_CLEAR;
         if ($urandom_range(3) == 0) k = {$urandom, $urandom};
         else                        k = pool[$urandom_range(POOL_SIZE - 1)];
         send_request(act, k);
      end
   endtask

   initial begin
      logic [CAP_W-1:0] cap_plan [9];
      logic [KEY_W-1:0] ka, kb, kc, kd, ke, kf;
      cap_plan = '{5'd31, 5'd3, 5'd16, 5'd0, 5'd9, 5'd1, 5'd20, 5'd6, 5'd14};
      ka = 64'h0123_4567_89AB_CDEF;
      kb = 64'hFEDC_BA98_7654_3210;
      kc = 64'h8000_0000_0000_0001;
      kd = 64'h7FFF_FFFF_FFFF_FFFE;
      ke = 64'hA5A5_5A5A_C3C3_3C3C;
      kf = 64'h0000_0001_0000_0000;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes of the key, every action, refresh and clear at full capacity
      send_request(ACT_LOOKUP, '0);
      send_request(ACT_INSERT, '0);
      send_request(ACT_INSERT, '1);
      send_request(ACT_LOOKUP, '1);
      send_request(ACT_SPARE, '0);
      send_request(ACT_INSERT, '0);
      send_request(ACT_CLEAR, {$urandom, $urandom});
      send_request(ACT_LOOKUP, '0);
      send_request(ACT_INSERT, ka);
      send_request(ACT_INSERT, kb);
      send_request(ACT_INSERT, kc);
      send_request(ACT_INSERT, kd);
      send_request(ACT_INSERT, ke);

      // capacity lowered below occupancy: refresh keeps all, a new key evicts many
      drain_results();
      write_capacity(5'd1);
      send_request(ACT_INSERT, kc);
      send_request(ACT_LOOKUP, ka);
      send_request(ACT_INSERT, kf);

      // capacity two: plain oldest-first eviction
      drain_results();
      write_capacity(5'd2);
      send_request(ACT_INSERT, ka);
      send_request(ACT_INSERT, kb);
      send_request(ACT_LOOKUP, kf);

      // capacity zero: inserts change nothing, presence still reported
      drain_results();
      write_capacity(5'd0);
      send_request(ACT_INSERT, kc);
      send_request(ACT_INSERT, ka);
      send_request(ACT_LOOKUP, ka);

      // capacity above the slot count saturates
      drain_results();
      write_capacity(5'd31);
      send_request(ACT_INSERT, kc);
      send_request(ACT_CLEAR, '1);

      // three idling mixes, three capacity settings each
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 29;
               receiver_stall_pct = 80;
            end
            1: begin
               sender_idle_pct    = 80;
               receiver_stall_pct = 29;
            end
            default: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 3; seg++) begin
            drain_results();
            write_capacity(cap_plan[phase * 3 + seg]);
            // long receiver hold-off while requests keep coming
            if (phase == 2 && seg == 0) hold_asked = hold_asked + 1;
            run_segment(SEGMENT_ITEMS);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.owed_outcomes.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lps_pkg.sv
rtl/lps_tag_match.sv
rtl/lru_presence_set_unit.sv
tb/lru_presence_set_unit_test.sv
